### rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property at every rising edge of clk, with reset masking it.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Checks that cond in one cycle implies res in the next cycle.
`define ASSERT_NEXT(lbl, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEXT(lbl, cond, res)
`endif
`endif

### rtl/ppp_pkg.sv
// Package of constants and register indexes for the perspective projection block.
package ppp_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CAM_X        = 3'd0,
        REG_CAM_Y        = 3'd1,
        REG_CAM_Z        = 3'd2,
        REG_FOCAL_LENGTH = 3'd3,
        REG_NEAR_EPSILON = 3'd4
    } cfg_index_t;
endpackage

### rtl/ppp_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, for two axes sharing a divisor.
`include "assert_macros.svh"
module ppp_divpipe import ppp_pkg::*; #(
    parameter int DEN_W  = COORD_WIDTH_DEF + 1,
    parameter int NUM_W  = 2 * COORD_WIDTH_DEF,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  num_x,
    input  logic [NUM_W-1:0]  num_y,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NUM_W-1:0]  quo_x,
    output logic [NUM_W-1:0]  quo_y,
    output logic [SIDE_W-1:0] side_out
);
    localparam int N = NUM_W;

    logic              v_reg    [N];
    logic [DEN_W-1:0]  rx_reg   [N];
    logic [DEN_W-1:0]  ry_reg   [N];
    logic [NUM_W-1:0]  px_reg   [N];
    logic [NUM_W-1:0]  py_reg   [N];
    logic [DEN_W-1:0]  d_reg    [N];
    logic [SIDE_W-1:0] s_reg    [N];
    logic              rdy      [N+1];

    assign rdy[N] = out_ready;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_stage
            logic              v_prev;
            logic [DEN_W-1:0]  rx_prev, ry_prev, d_prev;
            logic [NUM_W-1:0]  px_prev, py_prev;
            logic [SIDE_W-1:0] s_prev;
            logic [DEN_W:0]    tx, ty;
            logic [DEN_W-1:0]  rx_next, ry_next;
            logic [NUM_W-1:0]  px_next, py_next;

            if (i == 0) begin : g_first
                assign v_prev  = in_valid;
                assign rx_prev = '0;
                assign ry_prev = '0;
                assign px_prev = num_x;
                assign py_prev = num_y;
                assign d_prev  = den;
                assign s_prev  = side_in;
            end else begin : g_rest
                assign v_prev  = v_reg[i-1];
                assign rx_prev = rx_reg[i-1];
                assign ry_prev = ry_reg[i-1];
                assign px_prev = px_reg[i-1];
                assign py_prev = py_reg[i-1];
                assign d_prev  = d_reg[i-1];
                assign s_prev  = s_reg[i-1];
            end

            assign rdy[i] = !v_reg[i] || rdy[i+1];

            // Shift in the next dividend bit, then subtract when the divisor fits.
            always_comb
            begin
                tx = {rx_prev, px_prev[NUM_W-1]};
                ty = {ry_prev, py_prev[NUM_W-1]};
                if (tx >= {1'b0, d_prev})
                begin
                    rx_next = DEN_W'(tx - {1'b0, d_prev});
                    px_next = {px_prev[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rx_next = tx[DEN_W-1:0];
                    px_next = {px_prev[NUM_W-2:0], 1'b0};
                end
                if (ty >= {1'b0, d_prev})
                begin
                    ry_next = DEN_W'(ty - {1'b0, d_prev});
                    py_next = {py_prev[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    ry_next = ty[DEN_W-1:0];
                    py_next = {py_prev[NUM_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (rdy[i])
                    v_reg[i] <= v_prev;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i] && v_prev)
                begin
                    rx_reg[i] <= rx_next;
                    ry_reg[i] <= ry_next;
                    px_reg[i] <= px_next;
                    py_reg[i] <= py_next;
                    d_reg[i]  <= d_prev;
                    s_reg[i]  <= s_prev;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign quo_x     = px_reg[N-1];
    assign quo_y     = py_reg[N-1];
    assign side_out  = s_reg[N-1];

    // The partial remainder must always stay below the divisor.
    `ASSERT_CLK(a_rem_x_below_den, !v_reg[N-1] || rx_reg[N-1] < d_reg[N-1])
    `ASSERT_CLK(a_rem_y_below_den, !v_reg[N-1] || ry_reg[N-1] < d_reg[N-1])
    // A stalled last stage keeps its item.
    `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(quo_x))
endmodule

### rtl/perspective_point_projection.sv
// Top level of the pinhole perspective projection block.
// Each item is one world point; the block subtracts the camera position, clamps
// the depth away from zero by the near epsilon, and returns dx*f/dz and dy*f/dz
// truncated toward zero, the clamped depth, and a saturation flag. One item is
// accepted per clock unless out_ready stalls the pipeline, which holds three
// front stages (subtract, clamp and magnitude, multiply), one stage per quotient
// bit in the divider pipeline, and the saturating output register. Configuration
// registers are written through a plain write port and must only change while
// the pipeline holds no item.
`include "assert_macros.svh"
module perspective_point_projection import ppp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] screen_x,
    output logic signed [COORD_WIDTH-1:0] screen_y,
    output logic signed [COORD_WIDTH-1:0] depth,
    output logic                          overflow
);
    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int PW     = 2 * W;
    localparam int SIDE_W = 2 + DW;
    localparam logic [W-2:0] FOCAL_RESET = (W-1)'(64'd1 << FRAC_BITS);
    localparam logic [W-2:0] EPS_RESET   = (W-1)'((64'd1 << FRAC_BITS) / 100);

    // Configuration registers.
    logic signed [W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [W-2:0]        focal_reg, eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            focal_reg <= FOCAL_RESET;
            eps_reg   <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAM_X:        cam_x_reg <= cfg_data;
                REG_CAM_Y:        cam_y_reg <= cfg_data;
                REG_CAM_Z:        cam_z_reg <= cfg_data;
                REG_FOCAL_LENGTH: focal_reg <= cfg_data[W-2:0];
                REG_NEAR_EPSILON: eps_reg   <= cfg_data[W-2:0];
                default:          ;
            endcase
        end
    end

    // Pipeline handshake: each stage loads when it is empty or its item moves on.
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic s1_rdy, s2_rdy, s3_rdy, out_rdy, div_in_ready, div_out_valid;

    assign out_rdy  = !out_v_reg || out_ready;
    assign s3_rdy   = !s3_v_reg || div_in_ready;
    assign s2_rdy   = !s2_v_reg || s3_rdy;
    assign s1_rdy   = !s1_v_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)  s1_v_reg  <= in_valid;
            if (s2_rdy)  s2_v_reg  <= s1_v_reg;
            if (s3_rdy)  s3_v_reg  <= s2_v_reg;
            if (out_rdy) out_v_reg <= div_out_valid;
        end
    end

    // Stage 1: camera-relative offsets at one extra bit, so they never wrap.
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            dx_reg <= DW'(point_x) - DW'(cam_x_reg);
            dy_reg <= DW'(point_y) - DW'(cam_y_reg);
            dz_reg <= DW'(point_z) - DW'(cam_z_reg);
        end
    end

    // Stage 2: clamp the depth, take magnitudes and quotient signs.
    logic signed [DW-1:0] eps_s, dzc_next;
    logic [DW-1:0]        magx_reg, magy_reg, den_reg;
    logic signed [DW-1:0] dzc_reg, dzc3_reg;
    logic                 negx_reg, negy_reg;

    always_comb
    begin
        // A zero epsilon is treated as one so that the divisor is never zero.
        eps_s = (eps_reg == '0) ? DW'(1) : signed'({2'b00, eps_reg});
        if (dz_reg > -eps_s && dz_reg < eps_s)
            dzc_next = dz_reg[DW-1] ? -eps_s : eps_s;
        else
            dzc_next = dz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_v_reg)
        begin
            magx_reg <= dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
            magy_reg <= dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
            den_reg  <= dzc_next[DW-1] ? DW'(-dzc_next) : DW'(dzc_next);
            negx_reg <= dx_reg[DW-1] ^ dzc_next[DW-1];
            negy_reg <= dy_reg[DW-1] ^ dzc_next[DW-1];
            dzc_reg  <= dzc_next;
        end
    end

    // Stage 3: exact products of the magnitudes with the focal length.
    logic [PW-1:0]  prodx_reg, prody_reg;
    logic [DW-1:0]  den3_reg;
    logic           negx3_reg, negy3_reg;

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_v_reg)
        begin
            prodx_reg <= PW'(magx_reg * focal_reg);
            prody_reg <= PW'(magy_reg * focal_reg);
            den3_reg  <= den_reg;
            negx3_reg <= negx_reg;
            negy3_reg <= negy_reg;
            dzc3_reg  <= dzc_reg;
        end
    end

    // Divider pipeline.
    logic [PW-1:0]     qx, qy;
    logic [SIDE_W-1:0] side_q;

    ppp_divpipe #(
        .DEN_W  (DW),
        .NUM_W  (PW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .in_ready  (div_in_ready),
        .num_x     (prodx_reg),
        .num_y     (prody_reg),
        .den       (den3_reg),
        .side_in   ({negx3_reg, negy3_reg, dzc3_reg}),
        .out_valid (div_out_valid),
        .out_ready (out_rdy),
        .quo_x     (qx),
        .quo_y     (qy),
        .side_out  (side_q)
    );

    // Output stage: restore signs and saturate each result to COORD_WIDTH bits.
    localparam logic [PW-1:0] POS_LIM = PW'((64'd1 << (W-1)) - 1);
    localparam logic [PW-1:0] NEG_LIM = PW'(64'd1 << (W-1));
    localparam logic signed [DW-1:0] D_MAX = DW'((64'd1 << (W-1)) - 1);
    localparam logic signed [DW-1:0] D_MIN = -D_MAX - DW'(1);

    logic                 nx, ny, ox, oy, od;
    logic signed [DW-1:0] dq;
    logic [PW-1:0]        limx, limy, ax, ay;
    logic [W-1:0]         sx_next, sy_next, d_next;

    always_comb
    begin
        nx   = side_q[SIDE_W-1];
        ny   = side_q[SIDE_W-2];
        dq   = signed'(side_q[DW-1:0]);
        limx = nx ? NEG_LIM : POS_LIM;
        limy = ny ? NEG_LIM : POS_LIM;
        ox   = qx > limx;
        oy   = qy > limy;
        ax   = ox ? limx : qx;
        ay   = oy ? limy : qy;
        sx_next = nx ? W'(-ax) : W'(ax);
        sy_next = ny ? W'(-ay) : W'(ay);
        od = 1'b0;
        if (dq > D_MAX)
        begin
            d_next = W'(D_MAX);
            od = 1'b1;
        end
        else if (dq < D_MIN)
        begin
            d_next = W'(D_MIN);
            od = 1'b1;
        end
        else
            d_next = W'(dq);
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_out_valid)
        begin
            screen_x <= sx_next;
            screen_y <= sy_next;
            depth    <= d_next;
            overflow <= ox | oy | od;
        end
    end

    assign out_valid = out_v_reg;

    // The front stage always takes an item when it holds none.
    `ASSERT_CLK(a_empty_front_ready, s1_v_reg || in_ready)
    // A waiting result stays put until it is taken.
    `ASSERT_NEXT(a_out_holds, out_valid && !out_ready,
                 out_valid && $stable(screen_x) && $stable(depth))
    // A clamped depth is never zero, even after saturation.
    `ASSERT_CLK(a_depth_nonzero, !out_valid || depth != '0)
endmodule
